// File: hdl/sbg_pkg.sv
// Shared types, constants and byte helpers for the 8.3 basis name generator.
// No dependencies; imported by every module under hdl.
package sbg_pkg;

    localparam logic [7:0] SPACE_CHAR      = 8'h20;
    localparam logic [7:0] DOT_CHAR        = 8'h2E;
    localparam logic [7:0] UNDERSCORE_CHAR = 8'h5F;
    localparam logic [7:0] LOWER_LO        = 8'h60;
    localparam logic [7:0] LOWER_HI        = 8'h7B;
    localparam logic [7:0] CASE_OFFSET     = 8'h20;

    localparam int          BASE_LEN    = 8;
    localparam int          EXT_LEN     = 3;
    localparam logic [3:0]  BASE_FULL   = 4'd8;
    localparam logic [1:0]  EXT_FULL    = 2'd3;
    localparam logic [63:0] BASE_BLANK  = {BASE_LEN{SPACE_CHAR}};
    localparam logic [23:0] EXT_BLANK   = {EXT_LEN{SPACE_CHAR}};

    // Queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [7:0] char_code;
        logic       is_last;
    } in_item_t;

    typedef struct packed {
        logic [63:0] base_name;
        logic [23:0] extension;
    } out_item_t;

    // Classified byte as it travels from front to back
    typedef struct packed {
        logic       is_space;
        logic       is_dot;
        logic [7:0] base_char;
        logic [7:0] ext_char;
        logic       is_last;
    } class_item_t;

    function automatic logic [7:0] upper_byte(input logic [7:0] b);
        logic [7:0] r;
        r = ((b > LOWER_LO) && (b < LOWER_HI)) ? (b - CASE_OFFSET) : b;
        return r;
    endfunction

    function automatic logic is_punct(input logic [7:0] b);
        logic r;
        case (b)
            8'h21, 8'h23, 8'h24, 8'h25, 8'h26,
            8'h27, 8'h28, 8'h29, 8'h40, 8'h5E,
            8'h5F, 8'h60, 8'h7B, 8'h7D, 8'h7E: r = 1'b1;
            default:                           r = 1'b0;
        endcase
        return r;
    endfunction

endpackage

// File: hdl/sbg_front.sv
// Front end: accept name bytes and classify them for the back end.
// Depends on sbg_pkg.
module sbg_front (
    input  logic                in_valid,
    output logic                in_stall,
    input  sbg_pkg::in_item_t   in_data,
    input  logic                queue_full,
    output logic                push,
    output sbg_pkg::class_item_t push_data
);
    import sbg_pkg::*;

    assign in_stall = queue_full;
    assign push     = in_valid && !queue_full;

    always_comb
    begin
        push_data.is_space  = (in_data.char_code == SPACE_CHAR);
        push_data.is_dot    = (in_data.char_code == DOT_CHAR);
        push_data.base_char = is_punct(in_data.char_code) ? UNDERSCORE_CHAR
                                                          : upper_byte(in_data.char_code);
        push_data.ext_char  = upper_byte(in_data.char_code);
        push_data.is_last   = in_data.is_last;
    end

endmodule

// File: hdl/sbg_queue.sv
// Short register queue decoupling the front and back ends.
// Depends on sbg_pkg.
module sbg_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  sbg_pkg::class_item_t push_data,
    output logic                 full,
    input  logic                 pop,
    output logic                 pop_valid,
    output sbg_pkg::class_item_t pop_data
);
    import sbg_pkg::*;

    class_item_t             entry_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CNT_W-1:0]  count_reg, count_next;

    assign full      = (count_reg == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_data  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("queue push while full");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> pop_valid)
        else $error("queue pop while empty");
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QUEUE_CNT_W'(QUEUE_DEPTH))
        else $error("queue count out of range");
`endif

endmodule

// File: hdl/sbg_back.sv
// Back end: build base and extension from classified bytes, hold the result.
// Depends on sbg_pkg.
module sbg_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 pop_valid,
    input  sbg_pkg::class_item_t pop_data,
    output logic                 pop,
    output logic                 out_valid,
    input  logic                 out_stall,
    output sbg_pkg::out_item_t   out_data
);
    import sbg_pkg::*;

    logic        skip_reg, skip_next;
    logic        base_done_reg, base_done_next;
    logic [3:0]  base_count_reg, base_count_next;
    logic [63:0] base_reg, base_next;
    logic        ext_open_reg, ext_open_next;
    logic [1:0]  ext_count_reg, ext_count_next;
    logic [23:0] ext_reg, ext_next;
    logic        out_valid_reg, out_valid_next;
    out_item_t   out_data_reg;

    logic        step_skip, step_base_done, step_ext_open, consumed, finish;
    logic [3:0]  step_base_count;
    logic [63:0] step_base;
    logic [1:0]  step_ext_count;
    logic [23:0] step_ext;

    // Take a byte unless it ends a name while a finished name waits and cannot leave
    assign pop       = pop_valid && (!pop_data.is_last || !out_valid_reg || !out_stall);
    assign finish    = pop && pop_data.is_last;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        step_skip       = skip_reg;
        step_base_done  = base_done_reg;
        step_base_count = base_count_reg;
        step_base       = base_reg;
        step_ext_open   = ext_open_reg;
        step_ext_count  = ext_count_reg;
        step_ext        = ext_reg;
        consumed        = 1'b0;

        if (pop)
        begin
            if (skip_reg)
            begin
                if (pop_data.is_space || pop_data.is_dot)
                begin
                    consumed = 1'b1;
                end
                else
                begin
                    step_skip = 1'b0;
                end
            end
            if (!consumed)
            begin
                if (!base_done_reg)
                begin
                    if (pop_data.is_dot)
                    begin
                        step_base_done = 1'b1;
                        step_ext_open  = 1'b1;
                        step_ext_count = '0;
                        step_ext       = EXT_BLANK;
                    end
                    else if (!pop_data.is_space)
                    begin
                        for (int i = 0; i < BASE_LEN; i++)
                        begin
                            if (base_count_reg[2:0] == 3'(i))
                            begin
                                step_base[(BASE_LEN-1-i)*8 +: 8] = pop_data.base_char;
                            end
                        end
                        step_base_count = base_count_reg + 1'b1;
                        if (step_base_count >= BASE_FULL)
                        begin
                            step_base_count = BASE_FULL;
                            step_base_done  = 1'b1;
                        end
                    end
                end
                else if (pop_data.is_dot)
                begin
                    // A later dot restarts the extension
                    step_ext_open  = 1'b1;
                    step_ext_count = '0;
                    step_ext       = EXT_BLANK;
                end
                else if (ext_open_reg && (ext_count_reg < EXT_FULL))
                begin
                    for (int j = 0; j < EXT_LEN; j++)
                    begin
                        if (ext_count_reg == 2'(j))
                        begin
                            step_ext[(EXT_LEN-1-j)*8 +: 8] = pop_data.ext_char;
                        end
                    end
                    step_ext_count = ext_count_reg + 1'b1;
                end
            end
        end

        if (finish)
        begin
            skip_next       = 1'b1;
            base_done_next  = 1'b0;
            base_count_next = '0;
            base_next       = BASE_BLANK;
            ext_open_next   = 1'b0;
            ext_count_next  = '0;
            ext_next        = EXT_BLANK;
        end
        else
        begin
            skip_next       = step_skip;
            base_done_next  = step_base_done;
            base_count_next = step_base_count;
            base_next       = step_base;
            ext_open_next   = step_ext_open;
            ext_count_next  = step_ext_count;
            ext_next        = step_ext;
        end

        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (finish)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skip_reg       <= 1'b1;
            base_done_reg  <= 1'b0;
            base_count_reg <= '0;
            base_reg       <= BASE_BLANK;
            ext_open_reg   <= 1'b0;
            ext_count_reg  <= '0;
            ext_reg        <= EXT_BLANK;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            skip_reg       <= skip_next;
            base_done_reg  <= base_done_next;
            base_count_reg <= base_count_next;
            base_reg       <= base_next;
            ext_open_reg   <= ext_open_next;
            ext_count_reg  <= ext_count_next;
            ext_reg        <= ext_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (finish)
        begin
            out_data_reg.base_name <= step_base;
            out_data_reg.extension <= step_ext;
        end
    end

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        base_count_reg <= BASE_FULL)
        else $error("base count beyond eight");
    a_full_means_done: assert property (@(posedge clk) disable iff (!rst_n)
        (base_count_reg == BASE_FULL) |-> base_done_reg)
        else $error("base full but not finished");
    a_reset_after_name: assert property (@(posedge clk) disable iff (!rst_n)
        finish |=> (skip_reg && !base_done_reg && !ext_open_reg && out_valid_reg))
        else $error("state not cleared after last byte");
`endif

endmodule

// File: hdl/short_name_basis_generator_unit.sv
// 8.3 basis name generator: one long-name byte per transaction, one result per name.
// The last byte of a name passes the queue; the name is registered when it is popped.
// Throughput: one byte per cycle unless the queue is full, set by the back end update;
// the two-entry queue and the output register let input continue while a result waits.
// Reset (rst_n low, asynchronous): queue empty, no result pending, name state blank.
// Depends on sbg_pkg, sbg_front, sbg_queue, sbg_back.
module short_name_basis_generator_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  sbg_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_stall,
    output sbg_pkg::out_item_t out_data
);
    import sbg_pkg::*;

    // Front to queue
    logic        push;
    class_item_t push_data;
    logic        queue_full;

    // Queue to back
    logic        pop;
    logic        pop_valid;
    class_item_t pop_data;

    // Classify each accepted byte: space, dot, base form and extension form
    sbg_front u_front (
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_data    (in_data),
        .queue_full (queue_full),
        .push       (push),
        .push_data  (push_data)
    );

    // Hold classified bytes while the back end waits on a stalled result
    sbg_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (queue_full),
        .pop       (pop),
        .pop_valid (pop_valid),
        .pop_data  (pop_data)
    );

    // Advance the base/extension state one byte per cycle unless a last byte waits on a
    // stalled result; drop leading spaces and dots, register the finished name on the last byte
    sbg_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_data  (pop_data),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

// File: tb/sv/short_name_basis_generator_unit_tb.sv
// Self-checking testbench for short_name_basis_generator_unit: streams long names byte by byte
// and checks each 8.3 basis name against a behavioral prediction.
// Depends on sbg_pkg and the RTL under hdl; needs no other files.
module short_name_basis_generator_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sbg_pkg::*;

    // Generous ceiling on the whole run, in ns (2 ns per cycle).
    localparam int RUN_LIMIT_NS    = 400000;
    localparam int DRAIN_GUARD     = 20000;
    localparam int SETTLE_CYCLES   = 4;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int PHASE_BYTES     = 205;

    typedef enum int { IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH } idle_mode_t;

    localparam logic [7:0] PUNCT_BYTES [15] = '{
        8'h21, 8'h23, 8'h24, 8'h25, 8'h26, 8'h27, 8'h28, 8'h29,
        8'h40, 8'h5E, 8'h5F, 8'h60, 8'h7B, 8'h7D, 8'h7E
    };

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_stall;
    in_item_t  in_data   = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    out_item_t out_data;

    // Stimulus side: bytes waiting to be offered, filled by the sequencer below.
    in_item_t   pending_bytes [$];
    idle_mode_t idle_mode     = IDLE_NONE;
    logic       receiver_hold = 1'b0;

    // Basis names predicted for accepted names, oldest first.
    out_item_t  expected_basis_q [$];

    // Predicted name state, advanced on every accepted byte.
    logic        skip_lead;
    logic        base_done;
    logic [3:0]  base_cnt;
    logic [63:0] base_buf;
    logic        ext_open;
    logic [1:0]  ext_cnt;
    logic [23:0] ext_buf;

    int mismatch_count = 0;
    int bytes_accepted = 0;
    int names_accepted = 0;
    int names_checked  = 0;

    short_name_basis_generator_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    always #1 clk = ~clk;

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    function automatic logic [7:0] upcase_byte(input logic [7:0] b);
        if (b >= "a" && b <= "z")
            return b - 8'h20;
        return b;
    endfunction

    // Base characters: listed punctuation folds to underscore, letters go upper case.
    function automatic logic [7:0] fold_base_char(input logic [7:0] b);
        case (b)
            8'h21, 8'h23, 8'h24, 8'h25, 8'h26, 8'h27, 8'h28, 8'h29,
            8'h40, 8'h5E, 8'h5F, 8'h60, 8'h7B, 8'h7D, 8'h7E: return UNDERSCORE_CHAR;
            default:                                          return upcase_byte(b);
        endcase
    endfunction

    function automatic void clear_name_state();
        skip_lead = 1'b1;
        base_done = 1'b0;
        base_cnt  = '0;
        base_buf  = BASE_BLANK;
        ext_open  = 1'b0;
        ext_cnt   = '0;
        ext_buf   = EXT_BLANK;
    endfunction

    // Fold one accepted byte into the predicted state; on the last byte of a name,
    // queue the finished basis name and start over.
    function automatic void absorb_name_byte(input in_item_t it);
        logic [7:0] b;
        logic       taken;
        out_item_t  basis;
        b     = it.char_code;
        taken = 1'b0;
        if (skip_lead && (b == SPACE_CHAR || b == DOT_CHAR))
            taken = 1'b1;
        else
            skip_lead = 1'b0;
        if (!taken && !base_done) begin
            taken = 1'b1;
            if (b == DOT_CHAR) begin
                base_done = 1'b1;
                ext_open  = 1'b1;
                ext_cnt   = '0;
                ext_buf   = EXT_BLANK;
            end
            else if (b != SPACE_CHAR) begin
                base_buf[63 - 8 * base_cnt -: 8] = fold_base_char(b);
                base_cnt = base_cnt + 4'd1;
                if (base_cnt == BASE_FULL)
                    base_done = 1'b1;
            end
        end
        if (!taken) begin
            if (b == DOT_CHAR) begin
                // a later dot restarts the extension, so the last one wins
                ext_open = 1'b1;
                ext_cnt  = '0;
                ext_buf  = EXT_BLANK;
            end
            else if (ext_open && ext_cnt != EXT_FULL) begin
                ext_buf[23 - 8 * ext_cnt -: 8] = upcase_byte(b);
                ext_cnt = ext_cnt + 2'd1;
            end
        end
        if (it.is_last) begin
            basis.base_name = base_buf;
            basis.extension = ext_buf;
            expected_basis_q.push_back(basis);
            clear_name_state();
        end
    endfunction

    initial clear_name_state();

    // ------------------------------------------------------------------
    // Driver: offer pending bytes, hold a stalled transaction unchanged.
    // ------------------------------------------------------------------

    function automatic logic sender_pauses();
        case (idle_mode)
            IDLE_SENDER: return $urandom_range(99) < 60;
            IDLE_BOTH:   return $urandom_range(99) < 27;
            default:     return 1'b0;
        endcase
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data  <= '0;
        end
        else if (!in_valid || !in_stall)
        begin
            // A transaction completed at this edge: predict from the byte just taken.
            if (in_valid)
            begin
                absorb_name_byte(in_data);
                bytes_accepted++;
                if (in_data.is_last)
                    names_accepted++;
            end
            // Advance to the next byte, or drop in_valid to idle.
            if (pending_bytes.size() != 0 && !sender_pauses())
            begin
                in_data  <= pending_bytes.pop_front();
                in_valid <= 1'b1;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: check each delivered basis name, then pick the next stall.
    // ------------------------------------------------------------------

    function automatic logic receiver_pauses();
        case (idle_mode)
            IDLE_RECEIVER: return $urandom_range(99) < 60;
            IDLE_BOTH:     return $urandom_range(99) < 27;
            default:       return 1'b0;
        endcase
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_basis_q.size() == 0)
                begin
                    $error("unexpected result: base_name %h extension %h",
                           out_data.base_name, out_data.extension);
                    mismatch_count++;
                end
                else
                begin
                    out_item_t want;
                    want = expected_basis_q.pop_front();
                    names_checked++;
                    if (out_data.base_name !== want.base_name)
                    begin
                        $error("base_name mismatch: expected %h, actual %h",
                               want.base_name, out_data.base_name);
                        mismatch_count++;
                    end
                    if (out_data.extension !== want.extension)
                    begin
                        $error("extension mismatch: expected %h, actual %h",
                               want.extension, out_data.extension);
                        mismatch_count++;
                    end
                end
            end
            // Long hold-off wins over the random stall pattern.
            out_stall <= receiver_hold || receiver_pauses();
        end
    end

    // ------------------------------------------------------------------
    // Stimulus builders
    // ------------------------------------------------------------------

    task automatic push_byte(input logic [7:0] b, input logic last);
        in_item_t it;
        it.char_code = b;
        it.is_last   = last;
        pending_bytes.push_back(it);
    endtask

    task automatic push_name_str(input string s);
        for (int i = 0; i < s.len(); i++)
            push_byte(s[i], i == s.len() - 1);
    endtask

    // Mostly file-name-like characters, with a share of arbitrary bytes.
    function automatic logic [7:0] pick_name_char();
        int roll;
        roll = $urandom_range(99);
        if (roll < 35) return 8'($urandom_range("a", "z"));
        if (roll < 55) return 8'($urandom_range("A", "Z"));
        if (roll < 65) return 8'($urandom_range("0", "9"));
        if (roll < 80) return PUNCT_BYTES[$urandom_range(14)];
        if (roll < 86) return SPACE_CHAR;
        return 8'($urandom_range(255));
    endfunction

    // Queue one random name and return its length in bytes.
    task automatic queue_random_name(output int len);
        logic [7:0] name [$];
        int         kind;
        int         n;
        int         dots;
        kind = $urandom_range(99);
        if (kind < 15)
        begin
            // noise: arbitrary bytes, dots and spaces included by chance
            n = $urandom_range(1, 12);
            repeat (n) name.push_back(8'($urandom_range(255)));
        end
        else
        begin
            if ($urandom_range(3) == 0)
                repeat ($urandom_range(1, 3))
                    name.push_back($urandom_range(1) ? DOT_CHAR : SPACE_CHAR);
            repeat ($urandom_range(0, 11)) name.push_back(pick_name_char());
            n    = $urandom_range(99);
            dots = (n < 25) ? 0 : (n < 85) ? 1 : 2;
            repeat (dots)
            begin
                name.push_back(DOT_CHAR);
                repeat ($urandom_range(0, 4)) name.push_back(pick_name_char());
            end
            if (name.size() == 0)
                name.push_back(pick_name_char());
        end
        for (int i = 0; i < name.size(); i++)
            push_byte(name[i], i == name.size() - 1);
        len = name.size();
    endtask

    task automatic queue_random_bytes(input int target);
        int total;
        int len;
        total = 0;
        while (total < target)
        begin
            queue_random_name(len);
            total += len;
        end
    endtask

    // Wait for every queued byte to go in and every predicted name to come out.
    task automatic wait_until_drained();
        int guard;
        guard = 0;
        while ((pending_bytes.size() != 0 || in_valid || expected_basis_q.size() != 0)
               && guard < DRAIN_GUARD)
        begin
            @(negedge clk);
            guard++;
        end
    endtask

    // ------------------------------------------------------------------
    // Sequencer: reset, directed names, then one phase per idling pattern, then the hold-off.
    // Phase changes happen on the falling edge, away from the sampling edge.
    // ------------------------------------------------------------------

    initial
    begin
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed names, no idling:
        // leading dot dropped, punctuation folded, extension overflow ignored
        push_name_str(".a~c.txtz");
        // only spaces and dots: blank base and extension
        push_name_str(" .");
        // zero byte and 0xFF copied as they are, base space skipped, no dot
        push_byte(8'h00, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte("a", 1'b0);
        push_byte(SPACE_CHAR, 1'b0);
        push_byte("b", 1'b1);
        // full base drops the ninth byte, the later dot wins the extension
        push_name_str("abcdefghi.x.y");
        wait_until_drained();

        idle_mode = IDLE_NONE;
        queue_random_bytes(PHASE_BYTES);
        wait_until_drained();

        idle_mode = IDLE_SENDER;
        queue_random_bytes(PHASE_BYTES);
        wait_until_drained();

        idle_mode = IDLE_RECEIVER;
        queue_random_bytes(PHASE_BYTES);
        wait_until_drained();

        idle_mode = IDLE_BOTH;
        queue_random_bytes(PHASE_BYTES);
        wait_until_drained();

        // Hold the receiver off while the sender keeps offering, so the
        // internal queue fills and the input side stalls.
        idle_mode = IDLE_NONE;
        queue_random_bytes(PHASE_BYTES);
        receiver_hold = 1'b1;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
        receiver_hold = 1'b0;
        wait_until_drained();

        // Let any stray result surface before judging.
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (expected_basis_q.size() != 0)
        begin
            $error("%0d predicted names never delivered", expected_basis_q.size());
            mismatch_count++;
        end

        $display("Run covered %0d name bytes in %0d names; %0d basis names compared.",
                 bytes_accepted, names_accepted, names_checked);
        $display("Idling patterns: none, sender, receiver, both, and a long receiver hold-off.");
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // Hard stop if the run hangs.
    initial
    begin
        #(RUN_LIMIT_NS);
        $display("Mismatches found");
        $finish;
    end

endmodule

// File: files.f
hdl/sbg_pkg.sv
hdl/sbg_front.sv
hdl/sbg_queue.sv
hdl/sbg_back.sv
hdl/short_name_basis_generator_unit.sv
tb/sv/short_name_basis_generator_unit_tb.sv
